[sv/rfs_pkg.sv]
// rfs_pkg: shared types, constants and helpers of the roi frame statistics block
// no dependencies
`timescale 1ns / 1ps
package rfs_pkg;

  localparam int unsigned PixelBits = 13;
  localparam int unsigned MaxDim    = 8192;
  localparam int unsigned SumBits   = 39;
  localparam int unsigned SqBits    = 52;
  localparam int unsigned CntBits   = 27;
  localparam int unsigned DimBits   = 14;
  localparam int unsigned PosBits   = 13;

  localparam logic [PixelBits-1:0] SatLevel = 13'd8190;
  localparam logic [PixelBits-1:0] MinReset = 13'd8191;
  localparam logic [20:0]          Q8Max    = 21'd2096896;
  localparam logic [16:0]          PctMax   = 17'd102400;
  localparam logic [16:0]          PctScale = 17'd102400;

  // register indexes on the configuration port
  localparam logic [2:0] RegImageWidth   = 3'd0;
  localparam logic [2:0] RegImageHeight  = 3'd1;
  localparam logic [2:0] RegFullFrame    = 3'd2;
  localparam logic [2:0] RegWindowX      = 3'd3;
  localparam logic [2:0] RegWindowY      = 3'd4;
  localparam logic [2:0] RegWindowWidth  = 3'd5;
  localparam logic [2:0] RegWindowHeight = 3'd6;

  typedef struct packed {
    logic [DimBits-1:0] image_width;
    logic [DimBits-1:0] image_height;
    logic               full_frame;
    logic [DimBits-1:0] window_x;
    logic [DimBits-1:0] window_y;
    logic [DimBits-1:0] window_width;
    logic [DimBits-1:0] window_height;
  } cfg_t;

  // frame totals handed from front to back
  typedef struct packed {
    logic [PosBits-1:0]   x0;
    logic [PosBits-1:0]   y0;
    logic [DimBits-1:0]   rw;
    logic [DimBits-1:0]   rh;
    logic [CntBits-1:0]   count;
    logic [SumBits-1:0]   sum;
    logic [SqBits-1:0]    sumsq;
    logic [PixelBits-1:0] min_v;
    logic [PixelBits-1:0] max_v;
    logic [CntBits-1:0]   sat;
  } snap_t;

  function automatic logic [DimBits-1:0] clamp_dim(input logic [DimBits-1:0] v);
    logic [DimBits-1:0] r;
    if (v == '0) r = DimBits'(1);
    else if (v > DimBits'(MaxDim)) r = DimBits'(MaxDim);
    else r = v;
    return r;
  endfunction

endpackage

[sv/rfs_front.sv]
// rfs_front: raster position tracking, window test and per-pixel accumulation
// depends on rfs_pkg
`timescale 1ns / 1ps
module rfs_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rfs_pkg::cfg_t                  cfg_i,
  input  logic                           accept_i,
  input  logic [rfs_pkg::PixelBits-1:0]  pixel_i,
  output logic                           snap_push_o,
  output rfs_pkg::snap_t                 snap_o
);

  logic [rfs_pkg::PosBits-1:0]   col_q, col_d, line_q, line_d;
  logic [rfs_pkg::SumBits-1:0]   sum_q, sum_d;
  logic [rfs_pkg::SqBits-1:0]    sq_q, sq_d;
  logic [rfs_pkg::PixelBits-1:0] min_q, min_d, max_q, max_d;
  logic [rfs_pkg::CntBits-1:0]   sat_q, sat_d;

  logic [rfs_pkg::DimBits-1:0] w, h, rem_w, rem_h, rw, rh;
  logic [rfs_pkg::PosBits-1:0] wm1, hm1, x0, y0;
  logic [rfs_pkg::DimBits:0]   x_end, y_end;
  logic in_win, eol, eof;
  logic [2*rfs_pkg::PixelBits-1:0] pix_sq;
  logic [2*rfs_pkg::DimBits-1:0]   count_full;

  always_comb begin
    w   = rfs_pkg::clamp_dim(cfg_i.image_width);
    h   = rfs_pkg::clamp_dim(cfg_i.image_height);
    wm1 = rfs_pkg::PosBits'(w - 14'd1);
    hm1 = rfs_pkg::PosBits'(h - 14'd1);
    if (cfg_i.full_frame) begin
      x0 = '0;
      y0 = '0;
    end else begin
      x0 = (cfg_i.window_x > {1'b0, wm1}) ? wm1 : cfg_i.window_x[12:0];
      y0 = (cfg_i.window_y > {1'b0, hm1}) ? hm1 : cfg_i.window_y[12:0];
    end
    rem_w = w - {1'b0, x0};
    rem_h = h - {1'b0, y0};
    if (cfg_i.full_frame) begin
      rw = w;
      rh = h;
    end else begin
      rw = (cfg_i.window_width == '0) ? 14'd1 :
           (cfg_i.window_width > rem_w) ? rem_w : cfg_i.window_width;
      rh = (cfg_i.window_height == '0) ? 14'd1 :
           (cfg_i.window_height > rem_h) ? rem_h : cfg_i.window_height;
    end
    x_end  = {2'b0, x0} + {1'b0, rw};
    y_end  = {2'b0, y0} + {1'b0, rh};
    in_win = (col_q >= x0) && ({2'b0, col_q} < x_end) &&
             (line_q >= y0) && ({2'b0, line_q} < y_end);
    // a shrunken size ends the line or frame at once
    eol    = ({1'b0, col_q} + 14'd1) >= w;
    eof    = eol && (({1'b0, line_q} + 14'd1) >= h);
    pix_sq = pixel_i * pixel_i;
    count_full = rw * rh;
  end

  always_comb begin
    sum_d = sum_q;
    sq_d  = sq_q;
    min_d = min_q;
    max_d = max_q;
    sat_d = sat_q;
    if (in_win) begin
      sum_d = sum_q + rfs_pkg::SumBits'(pixel_i);
      sq_d  = sq_q + rfs_pkg::SqBits'(pix_sq);
      if (pixel_i < min_q) min_d = pixel_i;
      if (pixel_i > max_q) max_d = pixel_i;
      if (pixel_i >= rfs_pkg::SatLevel) sat_d = sat_q + 27'd1;
    end
    col_d  = eol ? '0 : col_q + 13'd1;
    line_d = eol ? line_q + 13'd1 : line_q;
  end

  assign snap_push_o  = accept_i && eof;
  assign snap_o.x0    = x0;
  assign snap_o.y0    = y0;
  assign snap_o.rw    = rw;
  assign snap_o.rh    = rh;
  assign snap_o.count = count_full[rfs_pkg::CntBits-1:0];
  assign snap_o.sum   = sum_d;
  assign snap_o.sumsq = sq_d;
  assign snap_o.min_v = min_d;
  assign snap_o.max_v = max_d;
  assign snap_o.sat   = sat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      line_q <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      min_q  <= rfs_pkg::MinReset;
      max_q  <= '0;
      sat_q  <= '0;
    end else if (accept_i) begin
      if (eof) begin
        col_q  <= '0;
        line_q <= '0;
        sum_q  <= '0;
        sq_q   <= '0;
        min_q  <= rfs_pkg::MinReset;
        max_q  <= '0;
        sat_q  <= '0;
      end else begin
        col_q  <= col_d;
        line_q <= line_d;
        sum_q  <= sum_d;
        sq_q   <= sq_d;
        min_q  <= min_d;
        max_q  <= max_d;
        sat_q  <= sat_d;
      end
    end
  end

endmodule

[sv/rfs_queue.sv]
// rfs_queue: two-entry queue of frame totals between front and back
// depends on rfs_pkg
`timescale 1ns / 1ps
module rfs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rfs_pkg::snap_t wdata_i,
  input  logic           pop_i,
  output rfs_pkg::snap_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);

  rfs_pkg::snap_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

[sv/rfs_back.sv]
// rfs_back: end-of-frame sequencer with shared serial multiplier, root and divider
// depends on rfs_pkg
`timescale 1ns / 1ps
module rfs_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  rfs_pkg::snap_t                q_data_i,
  output logic                          q_pop_o,
  input  logic                          out_pop_i,
  output logic                          out_valid_o,
  output rfs_pkg::snap_t                out_snap_o,
  output logic [20:0]                   out_mean_o,
  output logic [20:0]                   out_std_o,
  output logic [16:0]                   out_pct_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StSub  = 3'd2;
  localparam logic [2:0] StRoot = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  localparam logic [5:0] MulLast  = 6'd38;
  localparam logic [5:0] RootLast = 6'd47;
  localparam logic [5:0] DivLast  = 6'd47;

  logic [2:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic [5:0] step_q, step_d;

  rfs_pkg::snap_t snap_q, snap_d;
  logic [79:0] acc_q, acc_d, mcand_q, mcand_d, a_q, a_d, acc_nxt, diff;
  logic [38:0] mplier_q, mplier_d;
  logic [43:0] pnum_q, pnum_d;
  logic [95:0] rad_q, rad_d;
  logic [51:0] srem_q, srem_d, srem_sh, trial;
  logic [47:0] root_q, root_d, root_nxt;
  logic [47:0] dvd_q, dvd_d, quo_q, quo_d, quo_nxt;
  logic [27:0] drem_q, drem_d, drem_sh;
  logic [20:0] std_q, std_d, mean_q, mean_d, out_mean_q, out_mean_d, out_std_q, out_std_d;
  logic [16:0] out_pct_q, out_pct_d, pct_sat;
  logic [20:0] q8_sat;
  logic        out_valid_q, out_valid_d;
  rfs_pkg::snap_t out_snap_q, out_snap_d;

  always_comb begin
    acc_nxt  = mplier_q[0] ? acc_q + mcand_q : acc_q;
    diff     = (a_q > acc_q) ? a_q - acc_q : '0;
    srem_sh  = {srem_q[49:0], rad_q[95:94]};
    trial    = {2'b0, root_q, 2'b01};
    root_nxt = (srem_sh >= trial) ? {root_q[46:0], 1'b1} : {root_q[46:0], 1'b0};
    drem_sh  = {drem_q[26:0], dvd_q[47]};
    quo_nxt  = (drem_sh >= {1'b0, snap_q.count}) ? {quo_q[46:0], 1'b1} : {quo_q[46:0], 1'b0};
    q8_sat   = (quo_nxt > 48'(rfs_pkg::Q8Max)) ? rfs_pkg::Q8Max : quo_nxt[20:0];
    pct_sat  = (quo_nxt > 48'(rfs_pkg::PctMax)) ? rfs_pkg::PctMax : quo_nxt[16:0];
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    step_d      = step_q;
    snap_d      = snap_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    a_d         = a_q;
    pnum_d      = pnum_q;
    rad_d       = rad_q;
    srem_d      = srem_q;
    root_d      = root_q;
    dvd_d       = dvd_q;
    quo_d       = quo_q;
    drem_d      = drem_q;
    std_d       = std_q;
    mean_d      = mean_q;
    out_snap_d  = out_snap_q;
    out_mean_d  = out_mean_q;
    out_std_d   = out_std_q;
    out_pct_d   = out_pct_q;
    out_valid_d = out_valid_q && !out_pop_i;
    q_pop_o     = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (!q_empty_i) begin
          q_pop_o  = 1'b1;
          snap_d   = q_data_i;
          acc_d    = '0;
          mcand_d  = 80'(rfs_pkg::PctScale);
          mplier_d = 39'(q_data_i.sat);
          phase_d  = 2'd0;
          step_d   = '0;
          state_d  = StMul;
        end
      end
      StMul: begin
        acc_d    = acc_nxt;
        mcand_d  = {mcand_q[78:0], 1'b0};
        mplier_d = {1'b0, mplier_q[38:1]};
        step_d   = step_q + 6'd1;
        if (step_q == MulLast) begin
          step_d = '0;
          acc_d  = '0;
          unique case (phase_q)
            2'd0: begin
              pnum_d   = acc_nxt[43:0];
              mcand_d  = 80'(snap_q.sumsq);
              mplier_d = 39'(snap_q.count);
              phase_d  = 2'd1;
            end
            2'd1: begin
              a_d      = acc_nxt;
              mcand_d  = 80'(snap_q.sum);
              mplier_d = snap_q.sum;
              phase_d  = 2'd2;
            end
            default: begin
              acc_d   = acc_nxt;
              state_d = StSub;
            end
          endcase
        end
      end
      StSub: begin
        rad_d   = {diff, 16'b0};
        srem_d  = '0;
        root_d  = '0;
        step_d  = '0;
        state_d = StRoot;
      end
      StRoot: begin
        srem_d = (srem_sh >= trial) ? srem_sh - trial : srem_sh;
        root_d = root_nxt;
        rad_d  = {rad_q[93:0], 2'b0};
        step_d = step_q + 6'd1;
        if (step_q == RootLast) begin
          dvd_d   = root_nxt;
          drem_d  = '0;
          quo_d   = '0;
          step_d  = '0;
          phase_d = 2'd0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        drem_d = (drem_sh >= {1'b0, snap_q.count}) ? drem_sh - {1'b0, snap_q.count} : drem_sh;
        quo_d  = quo_nxt;
        dvd_d  = {dvd_q[46:0], 1'b0};
        step_d = step_q + 6'd1;
        if (step_q == DivLast) begin
          drem_d = '0;
          quo_d  = '0;
          step_d = '0;
          unique case (phase_q)
            2'd0: begin
              std_d   = q8_sat;
              dvd_d   = {1'b0, snap_q.sum, 8'b0};
              phase_d = 2'd1;
            end
            2'd1: begin
              mean_d  = q8_sat;
              dvd_d   = {4'b0, pnum_q};
              phase_d = 2'd2;
            end
            default: begin
              out_pct_d = pct_sat;
              state_d   = StDone;
            end
          endcase
        end
      end
      StDone: begin
        if (!out_valid_q || out_pop_i) begin
          out_snap_d  = snap_q;
          out_mean_d  = mean_q;
          out_std_d   = std_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // the percent result is parked until the output register frees up
  always_ff @(posedge clk_i) begin
    snap_q   <= snap_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    a_q      <= a_d;
    pnum_q   <= pnum_d;
    rad_q    <= rad_d;
    srem_q   <= srem_d;
    root_q   <= root_d;
    dvd_q    <= dvd_d;
    quo_q    <= quo_d;
    drem_q   <= drem_d;
    std_q    <= std_d;
    mean_q   <= mean_d;
    out_snap_q <= out_snap_d;
    out_mean_q <= out_mean_d;
    out_std_q  <= out_std_d;
  end

  logic [16:0] pct_hold_q;
  always_ff @(posedge clk_i) begin
    if (state_q == StDiv) pct_hold_q <= out_pct_d;
    if (state_q == StDone && (!out_valid_q || out_pop_i)) out_pct_q <= pct_hold_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_snap_o  = out_snap_q;
  assign out_mean_o  = out_mean_q;
  assign out_std_o   = out_std_q;
  assign out_pct_o   = out_pct_q;

endmodule

[sv/roi_frame_statistics_core.sv]
// roi_frame_statistics_core: top level with configuration registers, front, queue, back
// depends on rfs_pkg, rfs_front, rfs_queue, rfs_back
//
// channel   | direction | handshake              | payload
// config    | in        | psel/penable/pwrite    | paddr, pwdata, prdata
// pixels    | in        | push, full             | pixel_value_i
// results   | out       | empty, pop             | used_x_o .. saturation_pct_q10_o
//
// a pixel is taken every cycle while the totals queue has room
// after the last pixel the back end steps through queue pickup, three 39-step serial
// multiplies, a subtract, a 48-step square root, three 48-step divides and output load
// two frames of totals may queue while a result waits to be popped
// full is high while the totals queue holds two frames; reset clears all counters
`timescale 1ns / 1ps
module roi_frame_statistics_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [12:0] pixel_value_i,
  output logic        empty,
  input  logic        pop,
  output logic [12:0] used_x_o,
  output logic [12:0] used_y_o,
  output logic [13:0] used_width_o,
  output logic [13:0] used_height_o,
  output logic [26:0] pixel_count_o,
  output logic [12:0] min_value_o,
  output logic [12:0] max_value_o,
  output logic [20:0] mean_q8_o,
  output logic [20:0] std_q8_o,
  output logic [26:0] saturated_count_o,
  output logic [16:0] saturation_pct_q10_o
);

  rfs_pkg::cfg_t  cfg_q;
  rfs_pkg::snap_t snap_in, snap_out, res_snap;
  logic snap_push, q_pop, q_full, q_empty, out_valid, accept, wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width   <= 14'd1024;
      cfg_q.image_height  <= 14'd1024;
      cfg_q.full_frame    <= 1'b1;
      cfg_q.window_x      <= 14'd512;
      cfg_q.window_y      <= 14'd512;
      cfg_q.window_width  <= 14'd1024;
      cfg_q.window_height <= 14'd1024;
    end else if (wr_en) begin
      unique case (reg_idx)
        rfs_pkg::RegImageWidth:   cfg_q.image_width   <= pwdata[13:0];
        rfs_pkg::RegImageHeight:  cfg_q.image_height  <= pwdata[13:0];
        rfs_pkg::RegFullFrame:    cfg_q.full_frame    <= pwdata[0];
        rfs_pkg::RegWindowX:      cfg_q.window_x      <= pwdata[13:0];
        rfs_pkg::RegWindowY:      cfg_q.window_y      <= pwdata[13:0];
        rfs_pkg::RegWindowWidth:  cfg_q.window_width  <= pwdata[13:0];
        rfs_pkg::RegWindowHeight: cfg_q.window_height <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rfs_pkg::RegImageWidth:   prdata = 32'(cfg_q.image_width);
      rfs_pkg::RegImageHeight:  prdata = 32'(cfg_q.image_height);
      rfs_pkg::RegFullFrame:    prdata = 32'(cfg_q.full_frame);
      rfs_pkg::RegWindowX:      prdata = 32'(cfg_q.window_x);
      rfs_pkg::RegWindowY:      prdata = 32'(cfg_q.window_y);
      rfs_pkg::RegWindowWidth:  prdata = 32'(cfg_q.window_width);
      rfs_pkg::RegWindowHeight: prdata = 32'(cfg_q.window_height);
      default:                  prdata = '0;
    endcase
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  rfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .pixel_i     (pixel_value_i),
    .snap_push_o (snap_push),
    .snap_o      (snap_in)
  );

  rfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (snap_push),
    .wdata_i (snap_in),
    .pop_i   (q_pop),
    .rdata_o (snap_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  rfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (snap_out),
    .q_pop_o     (q_pop),
    .out_pop_i   (pop && out_valid),
    .out_valid_o (out_valid),
    .out_snap_o  (res_snap),
    .out_mean_o  (mean_q8_o),
    .out_std_o   (std_q8_o),
    .out_pct_o   (saturation_pct_q10_o)
  );

  assign empty             = !out_valid;
  assign used_x_o          = res_snap.x0;
  assign used_y_o          = res_snap.y0;
  assign used_width_o      = res_snap.rw;
  assign used_height_o     = res_snap.rh;
  assign pixel_count_o     = res_snap.count;
  assign min_value_o       = res_snap.min_v;
  assign max_value_o       = res_snap.max_v;
  assign saturated_count_o = res_snap.sat;

`ifndef ASSERT_OFF
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(snap_push && q_full)) else $error("totals pushed into a full queue");
  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty)) else $error("totals popped from an empty queue");
  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (mean_q8_o <= rfs_pkg::Q8Max && std_q8_o <= rfs_pkg::Q8Max))
    else $error("mean or deviation above range");
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> saturation_pct_q10_o <= rfs_pkg::PctMax)
    else $error("saturation share above range");
`endif

endmodule

[bench/roi_frame_statistics_core_tb.sv]
// roi_frame_statistics_core_tb: self-checking bench for the roi frame statistics block
// predicts every frame result from its own model of the block; depends on rfs_pkg
`timescale 1ns / 1ps
module roi_frame_statistics_core_tb;

  typedef struct {
    logic [12:0] ux, uy;
    logic [13:0] uw, uh;
    logic [26:0] cnt;
    logic [12:0] mn, mx;
    logic [20:0] mean, std;
    logic [26:0] sat;
    logic [16:0] pct;
  } frame_stats_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic [12:0] pixel_value_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [12:0] used_x_o, used_y_o, min_value_o, max_value_o;
  logic [13:0] used_width_o, used_height_o;
  logic [26:0] pixel_count_o, saturated_count_o;
  logic [20:0] mean_q8_o, std_q8_o;
  logic [16:0] saturation_pct_q10_o;

  roi_frame_statistics_core dut (.*);

  // model copy of the registers and accumulators
  logic [13:0] m_w = 14'd1024, m_h = 14'd1024, m_wx = 14'd512, m_wy = 14'd512;
  logic [13:0] m_ww = 14'd1024, m_wh = 14'd1024;
  logic        m_ff = 1'b1;
  int unsigned col_pos, line_pos;
  logic [38:0] acc_sum;
  logic [51:0] acc_sq;
  logic [12:0] acc_min, acc_max;
  logic [26:0] acc_sat;

  frame_stats_t pending_stats[$];
  int unsigned  errors = 0, frames_seen = 0, pixels_sent = 0;
  int unsigned  send_idle_pct = 0, pop_stall_pct = 0, hold_left = 0;
  longint unsigned cycles = 0;

  initial forever #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 64'd3000000) begin
      $display("timeout at %0t", $time);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int unsigned dim_of(logic [13:0] v);
    int unsigned r;
    if (v == 14'd0) r = 1;
    else if (v > 14'd8192) r = 8192;
    else r = 32'(v);
    return r;
  endfunction

  function automatic void clear_acc();
    col_pos = 0; line_pos = 0; acc_sum = '0; acc_sq = '0;
    acc_min = 13'd8191; acc_max = '0; acc_sat = '0;
  endfunction

  // advance the model by one pixel; pushes an expectation at end of frame
  function automatic void predict_pixel(logic [12:0] p);
    int unsigned w, h, x0, y0, rw, rh, lo, hi, mid;
    logic [127:0] cnt, a, b, d, t, mean, pct;
    frame_stats_t s;
    w = dim_of(m_w); h = dim_of(m_h);
    if (m_ff) begin
      x0 = 0; y0 = 0; rw = w; rh = h;
    end else begin
      x0 = 32'(m_wx) > w - 1 ? w - 1 : 32'(m_wx);
      y0 = 32'(m_wy) > h - 1 ? h - 1 : 32'(m_wy);
      rw = m_ww == 14'd0 ? 1 : (32'(m_ww) > w - x0 ? w - x0 : 32'(m_ww));
      rh = m_wh == 14'd0 ? 1 : (32'(m_wh) > h - y0 ? h - y0 : 32'(m_wh));
    end
    if (col_pos >= x0 && col_pos < x0 + rw && line_pos >= y0 && line_pos < y0 + rh) begin
      acc_sum = acc_sum + 39'(p);
      acc_sq  = acc_sq + 52'(p) * 52'(p);
      if (p < acc_min) acc_min = p;
      if (p > acc_max) acc_max = p;
      if (p >= rfs_pkg::SatLevel) acc_sat = acc_sat + 27'd1;
    end
    if (col_pos + 1 < w) begin
      col_pos++;
      return;
    end
    if (line_pos + 1 < h) begin
      col_pos = 0; line_pos++;
      return;
    end
    cnt  = 128'(rw) * 128'(rh);
    mean = (128'(acc_sum) << 8) / cnt;
    pct  = (128'(acc_sat) * 128'd102400) / cnt;
    if (mean > 128'(rfs_pkg::Q8Max)) mean = 128'(rfs_pkg::Q8Max);
    if (pct > 128'(rfs_pkg::PctMax)) pct = 128'(rfs_pkg::PctMax);
    a = cnt * 128'(acc_sq);
    b = 128'(acc_sum) * 128'(acc_sum);
    d = (a <= b) ? '0 : (a - b) << 16;
    lo = 0; hi = 32'(rfs_pkg::Q8Max);
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      t = 128'(mid) * cnt;
      if (t * t <= d) lo = mid; else hi = mid - 1;
    end
    s.ux = 13'(x0); s.uy = 13'(y0); s.uw = 14'(rw); s.uh = 14'(rh);
    s.cnt = 27'(cnt); s.mn = acc_min; s.mx = acc_max;
    s.mean = 21'(mean); s.std = 21'(lo); s.sat = acc_sat; s.pct = 17'(pct);
    pending_stats.push_back(s);
    clear_acc();
  endfunction

  // result side: check each popped result, then pick the next pop
  always @(posedge clk_i) begin
    frame_stats_t e;
    if (pop && !empty) begin
      frames_seen++;
      if (pending_stats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, used_x %0d count %0d", $time, used_x_o,
                 pixel_count_o);
      end else begin
        e = pending_stats.pop_front();
        if ({used_x_o, used_y_o, used_width_o, used_height_o, pixel_count_o, min_value_o,
             max_value_o, mean_q8_o, std_q8_o, saturated_count_o, saturation_pct_q10_o} !==
            {e.ux, e.uy, e.uw, e.uh, e.cnt, e.mn, e.mx, e.mean, e.std, e.sat, e.pct}) begin
          errors++;
          $display("%0t: mismatch exp x%0d y%0d w%0d h%0d n%0d mn%0d mx%0d %0d %0d %0d %0d",
                   $time, e.ux, e.uy, e.uw, e.uh, e.cnt, e.mn, e.mx, e.mean, e.std, e.sat,
                   e.pct);
          $display("%0t:          got x%0d y%0d w%0d h%0d n%0d mn%0d mx%0d %0d %0d %0d %0d",
                   $time, used_x_o, used_y_o, used_width_o, used_height_o, pixel_count_o,
                   min_value_o, max_value_o, mean_q8_o, std_q8_o, saturated_count_o,
                   saturation_pct_q10_o);
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  task automatic wait_drained();
    while (pending_stats.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // registers change only when the back end has gone quiet
  task automatic set_config(logic [13:0] w, logic [13:0] h, logic ff, logic [13:0] x,
                            logic [13:0] y, logic [13:0] ww, logic [13:0] wh);
    push <= 1'b0;
    wait_drained();
    repeat (400) @(posedge clk_i);
    write_reg(rfs_pkg::RegImageWidth, ({$urandom} & 32'hFFFF_C000) | 32'(w));
    write_reg(rfs_pkg::RegImageHeight, 32'(h));
    write_reg(rfs_pkg::RegFullFrame, 32'(ff));
    write_reg(rfs_pkg::RegWindowX, 32'(x));
    write_reg(rfs_pkg::RegWindowY, 32'(y));
    write_reg(rfs_pkg::RegWindowWidth, 32'(ww));
    write_reg(rfs_pkg::RegWindowHeight, 32'(wh));
    m_w = w; m_h = h; m_ff = ff; m_wx = x; m_wy = y; m_ww = ww; m_wh = wh;
  endtask

  task automatic send_pixel(logic [12:0] p);
    push <= 1'b1;
    pixel_value_i <= p;
    do @(posedge clk_i); while (full);
    pixels_sent++;
    predict_pixel(p);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      pixel_value_i <= 13'($urandom);
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  function automatic logic [12:0] pick_pixel();
    case ($urandom_range(9))
      0: return 13'd8191;
      1: return 13'd8190;
      2: return 13'd0;
      3: return 13'($urandom_range(8189, 8000));
      default: return 13'($urandom);
    endcase
  endfunction

  task automatic send_frame();
    int unsigned n;
    n = dim_of(m_w) * dim_of(m_h);
    repeat (n) send_pixel(pick_pixel());
  endtask

  function automatic logic [13:0] pick_dim();
    return $urandom_range(19) == 0 ? 14'($urandom) & 14'h3FFF : 14'($urandom_range(9));
  endfunction

  task automatic test_directed();
    set_config(1, 1, 1, 0, 0, 1, 1);
    send_pixel(13'd0);
    send_pixel(13'd8191);
    send_pixel(13'd8190);
    // zero size registers act as one
    set_config(0, 0, 1, 0, 0, 0, 0);
    send_pixel(13'd4095);
    set_config(3, 2, 1, 0, 0, 1, 1);
    send_pixel(13'd8191); send_pixel(13'd0); send_pixel(13'd8190);
    send_pixel(13'd1); send_pixel(13'd8191); send_pixel(13'd5461);
    // window origin past the image clamps to the last column and line
    set_config(3, 2, 0, 14'h3FFF, 14'd8192, 14'h3FFF, 14'h3FFF);
    send_pixel(13'd7); send_pixel(13'd8); send_pixel(13'd9);
    send_pixel(13'd10); send_pixel(13'd11); send_pixel(13'd8190);
    // zero window size acts as one
    set_config(4, 2, 0, 1, 0, 0, 0);
    repeat (8) send_pixel(13'd8191);
  endtask

  // large window registers against small images
  task automatic test_extreme_sizes();
    set_config(7, 1, 0, 14'd8191, 0, 14'd8192, 1);
    send_frame();
    set_config(1, 9, 0, 0, 14'd8000, 1, 14'h3FFF);
    send_frame();
    set_config(9, 5, 0, 2, 1, 14'h3FFF, 14'd8192);
    send_frame();
  endtask

  task automatic test_random(int unsigned idle, int unsigned stall, int unsigned n_pix);
    int unsigned start;
    send_idle_pct = idle; pop_stall_pct = stall;
    start = pixels_sent;
    while (pixels_sent - start < n_pix) begin
      if ($urandom_range(3) == 0)
        set_config(14'($urandom_range(12)), 14'($urandom_range(9)), 1'($urandom),
                   pick_dim(), pick_dim(), pick_dim(), pick_dim());
      else
        set_config(14'($urandom_range(8, 1)), 14'($urandom_range(6, 1)), 1'($urandom),
                   14'($urandom_range(9)), 14'($urandom_range(7)), 14'($urandom_range(9)),
                   14'($urandom_range(7)));
      repeat ($urandom_range(3, 1)) send_frame();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0; pop_stall_pct = 0;
    set_config(1, 1, 1, 0, 0, 1, 1);
    hold_left = 3000;
    repeat (12) send_pixel(pick_pixel());
    push <= 1'b0;
    // sender stays quiet until every result is out
    wait_drained();
    set_config(2, 2, 0, 1, 1, 1, 1);
    repeat (16) send_pixel(pick_pixel());
  endtask

  initial begin
    clear_acc();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_extreme_sizes();
    test_random(0, 0, 430);
    test_random(76, 0, 430);
    test_random(0, 76, 430);
    test_random(33, 33, 430);
    test_backpressure();
    push <= 1'b0;
    wait_drained();
    repeat (400) @(posedge clk_i);
    $display("covered %0d pixels in %0d frames: window clamps, size extremes, stalls",
             pixels_sent, frames_seen);
    if (errors == 0 && pending_stats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
